[sv/u8to16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; every other file uses these by scoped names.
package u8to16_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned COUNT_W = 10;
   localparam int unsigned SLOTS   = 3;

   localparam logic [COUNT_W-1:0] MAX_UNITS_RESET = 10'd127;
   localparam logic [UNIT_W-1:0]  REPLACEMENT_CHAR = 16'hFFFD;
   localparam logic [UNIT_W-1:0]  SURR_HIGH_BASE   = 16'hD800;
   localparam logic [UNIT_W-1:0]  SURR_LOW_BASE    = 16'hDC00;
   localparam logic [CP_W-1:0]    SUPP_OFFSET      = 21'h10000;
   localparam logic [CP_W-1:0]    BMP_MAX          = 21'h00FFFF;

   // one request as held in the input register
   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              has_byte;
      logic              end_of_text;
   } item_type;

   // up to three units produced by one request, slot 0 goes out first
   typedef struct packed {
      logic [SLOTS-1:0][UNIT_W-1:0] unit;
      logic [SLOTS-1:0]             last;
      logic [1:0]                   cnt;
   } bundle_type;

endpackage

[sv/u8to16_ifs.sv]
// Channel interfaces for the transcoder: request, response and register write.
// Depends on u8to16_pkg for field widths.
interface u8to16_req_if;
   logic                              valid;
   logic                              ready;
   logic [u8to16_pkg::BYTE_W-1:0]     in_byte;
   logic                              has_byte;
   logic                              end_of_text;

   modport source (output valid, in_byte, has_byte, end_of_text, input ready);
   modport sink   (input valid, in_byte, has_byte, end_of_text, output ready);
endinterface

interface u8to16_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [u8to16_pkg::UNIT_W-1:0]     code_unit;
   logic                              last_unit;

   modport source (output valid, code_unit, last_unit, input ready);
   modport sink   (input valid, code_unit, last_unit, output ready);
endinterface

interface u8to16_csr_if;
   logic                              valid;
   logic                              ready;
   logic [u8to16_pkg::COUNT_W-1:0]    wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

[sv/u8to16_decode.sv]
// Decoder state (gathered codepoint, bytes expected, units written) and the
// combinational decode of one registered request. Depends on u8to16_pkg.
module u8to16_decode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  u8to16_pkg::item_type                item,
   input  logic [u8to16_pkg::COUNT_W-1:0]      limit,
   output u8to16_pkg::bundle_type              bundle
);

   typedef struct packed {
      u8to16_pkg::bundle_type                 bun;
      logic [u8to16_pkg::CP_W-1:0]            pcp;
      logic [1:0]                             expect_cnt;
      logic [u8to16_pkg::COUNT_W-1:0]         uw;
   } work_type;

   logic [u8to16_pkg::CP_W-1:0]    pcp_ff, pcp_in;
   logic [1:0]                     exp_ff, exp_in;
   logic [u8to16_pkg::COUNT_W-1:0] uw_ff, uw_in;
   work_type                       w;

   function automatic work_type push(work_type s, logic [u8to16_pkg::UNIT_W-1:0] u,
                                     logic l);
      work_type r;
      r = s;
      case (s.bun.cnt)
         2'd0: begin
            r.bun.unit[0] = u;
            r.bun.last[0] = l;
         end
         2'd1: begin
            r.bun.unit[1] = u;
            r.bun.last[1] = l;
         end
         default: begin
            r.bun.unit[2] = u;
            r.bun.last[2] = l;
         end
      endcase
      r.bun.cnt = s.bun.cnt + 2'd1;
      return r;
   endfunction

   function automatic work_type emit(work_type s, logic [u8to16_pkg::CP_W-1:0] cp,
                                     logic [u8to16_pkg::COUNT_W-1:0] lim);
      work_type                    r;
      logic [u8to16_pkg::CP_W-1:0] v;
      r = s;
      v = cp - u8to16_pkg::SUPP_OFFSET;
      if (cp <= u8to16_pkg::BMP_MAX) begin
         r = push(r, cp[u8to16_pkg::UNIT_W-1:0], 1'b0);
         r.uw = s.uw + 10'd1;
      end else if ({1'b0, s.uw} + 11'd1 < {1'b0, lim}) begin
         // surrogate pair only when both halves fit
         r = push(r, u8to16_pkg::SURR_HIGH_BASE + {5'd0, v[20:10]}, 1'b0);
         r = push(r, u8to16_pkg::SURR_LOW_BASE + {6'd0, v[9:0]}, 1'b0);
         r.uw = s.uw + 10'd2;
      end
      return r;
   endfunction

   function automatic work_type lead(work_type s, logic [u8to16_pkg::BYTE_W-1:0] b,
                                     logic [u8to16_pkg::COUNT_W-1:0] lim);
      work_type r;
      r = s;
      if (s.uw < lim) begin
         if (b[7] == 1'b0) begin
            r = emit(r, {13'd0, b}, lim);
         end else if (b[7:5] == 3'b110) begin
            r.pcp        = {16'd0, b[4:0]};
            r.expect_cnt = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            r.pcp        = {17'd0, b[3:0]};
            r.expect_cnt = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            r.pcp        = {18'd0, b[2:0]};
            r.expect_cnt = 2'd3;
         end else begin
            r = emit(r, {5'd0, u8to16_pkg::REPLACEMENT_CHAR}, lim);
         end
      end
      return r;
   endfunction

   always_comb begin
      w            = '0;
      w.pcp        = pcp_ff;
      w.expect_cnt = exp_ff;
      w.uw         = uw_ff;
      if (item.has_byte) begin
         if (w.expect_cnt != 2'd0) begin
            if (item.in_byte[7:6] == 2'b10) begin
               w.pcp        = {w.pcp[14:0], item.in_byte[5:0]};
               w.expect_cnt = w.expect_cnt - 2'd1;
               if (w.expect_cnt == 2'd0) begin
                  w = emit(w, w.pcp, limit);
               end
            end else begin
               // broken sequence: replace, then decode this byte as a lead
               w.expect_cnt = 2'd0;
               w = emit(w, {5'd0, u8to16_pkg::REPLACEMENT_CHAR}, limit);
               w = lead(w, item.in_byte, limit);
            end
         end else begin
            w = lead(w, item.in_byte, limit);
         end
      end
      if (item.end_of_text) begin
         if (w.expect_cnt != 2'd0) begin
            w = emit(w, {5'd0, u8to16_pkg::REPLACEMENT_CHAR}, limit);
         end
         w            = push(w, '0, 1'b1);
         w.pcp        = '0;
         w.expect_cnt = 2'd0;
         w.uw         = '0;
      end
      pcp_in = w.pcp;
      exp_in = w.expect_cnt;
      uw_in  = w.uw;
      bundle = w.bun;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcp_ff <= '0;
         exp_ff <= '0;
         uw_ff  <= '0;
      end else if (advance) begin
         pcp_ff <= pcp_in;
         exp_ff <= exp_in;
         uw_ff  <= uw_in;
      end
   end

endmodule

[sv/u8to16_unit_buf.sv]
// Result register: holds the units of one request and sends one per cycle while ready.
// Depends on u8to16_pkg and u8to16_rsp_if.
module u8to16_unit_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  u8to16_pkg::bundle_type bundle,
   output logic                   can_take,
   u8to16_rsp_if.source           rsp_chan
);

   logic [u8to16_pkg::SLOTS-1:0][u8to16_pkg::UNIT_W-1:0] unit_ff;
   logic [u8to16_pkg::SLOTS-1:0]                         last_ff;
   logic [1:0]                                           left_ff;
   logic                                                 pop;

   assign pop                = (left_ff != 2'd0) && rsp_chan.ready;
   assign can_take           = (left_ff == 2'd0) || ((left_ff == 2'd1) && rsp_chan.ready);
   assign rsp_chan.valid     = (left_ff != 2'd0);
   assign rsp_chan.code_unit = unit_ff[0];
   assign rsp_chan.last_unit = last_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (load) begin
         left_ff <= bundle.cnt;
      end else if (pop) begin
         left_ff <= left_ff - 2'd1;
      end
   end

   // shift toward slot 0 as units leave
   always_ff @(posedge clock) begin
      if (load) begin
         unit_ff <= bundle.unit;
         last_ff <= bundle.last;
      end else if (pop) begin
         unit_ff[0] <= unit_ff[1];
         unit_ff[1] <= unit_ff[2];
         last_ff[0] <= last_ff[1];
         last_ff[1] <= last_ff[2];
      end
   end

endmodule

[sv/utf8_to_utf16_transcoder.sv]
// Top level: request register, decoder and result register of the UTF-8 to UTF-16
// transcoder. Depends on u8to16_pkg, u8to16_ifs, u8to16_decode, u8to16_unit_buf.
//
// Accepts one UTF-8 byte per request and returns UTF-16 code units, ending each
// text with a zero unit flagged last_unit. A request is taken every cycle while
// each produces at most one unit and the response port is ready; that port sends
// one unit per cycle while ready, so a request yielding two or three units
// (surrogate pair, replacement plus lead, terminator) holds the request port until
// its last unit goes out. A request passes the request and result registers before
// its first unit is sent. The unit limit (csr write data) is capped at UNIT_COUNT_MAX
// and should be written only while the block is idle; it resets to 127.
module utf8_to_utf16_transcoder #(
   parameter int unsigned UNIT_COUNT_MAX = 1023
) (
   input  logic          clock,
   input  logic          reset,
   u8to16_req_if.sink    req_chan,
   u8to16_rsp_if.source  rsp_chan,
   u8to16_csr_if.sink    csr_chan
);

   logic                              in_valid_ff;
   u8to16_pkg::item_type              in_ff;
   logic [u8to16_pkg::COUNT_W-1:0]    max_units_ff;
   logic [u8to16_pkg::COUNT_W-1:0]    limit;
   logic                              advance;
   logic                              can_take;
   u8to16_pkg::bundle_type            bundle;

   assign csr_chan.ready = 1'b1;
   assign limit = (32'(max_units_ff) > UNIT_COUNT_MAX) ?
                  u8to16_pkg::COUNT_W'(UNIT_COUNT_MAX) : max_units_ff;

   assign advance        = in_valid_ff && can_take;
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_units_ff <= u8to16_pkg::MAX_UNITS_RESET;
      end else if (csr_chan.valid) begin
         max_units_ff <= csr_chan.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ff.in_byte     <= req_chan.in_byte;
         in_ff.has_byte    <= req_chan.has_byte;
         in_ff.end_of_text <= req_chan.end_of_text;
      end
   end

   u8to16_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_ff),
      .limit   (limit),
      .bundle  (bundle)
   );

   // requests that yield no unit pass straight through
   u8to16_unit_buf u_unit_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && (bundle.cnt != 2'd0)),
      .bundle   (bundle),
      .can_take (can_take),
      .rsp_chan (rsp_chan)
   );

endmodule
